@@ sv/msm_pkg.sv @@
// Package for the multi-voice synthesizer: sizes, envelope state codes,
// sequencer codes and the noise byte mapping. No dependencies.
`default_nettype none
package msm_pkg;
  localparam int VOICES = 4;
  localparam int VW = 2;
  localparam logic [1:0] ST_RELEASE = 2'd0;
  localparam logic [1:0] ST_ATTACK = 2'd1;
  localparam logic [1:0] ST_DECAY = 2'd2;
  localparam logic [1:0] ST_SUSTAIN = 2'd3;
  localparam logic OP_LOAD = 1'b0;
  localparam logic [23:0] LVL_MAX = 24'hffffff;
  localparam logic [27:0] PH_HALF = 28'h8000000;
  localparam logic [22:0] LFSR_INIT = 23'h7ffff8;

  typedef struct packed {
    logic start;
    logic [55:0] num;
    logic [27:0] den;
  } div_req_t;

  function automatic logic [7:0] noise_map(input logic [22:0] s);
    noise_map = {s[22], s[20], s[16], s[13], s[11], s[7], s[4], s[2]};
  endfunction
endpackage
`default_nettype wire

@@ sv/multi_voice_synth_mixer.sv @@
// Top level of the multi-voice synthesizer with mixer.
// Depends on msm_pkg and msm_div.
`default_nettype none
// A load request writes one voice's settings. A sample request steps the
// voices one after another: each enabled voice goes through the steps
// envelope, phase, waveform, scale and accumulate, plus a divider pass when
// hard sync fires, for the sync product goes through a bit-serial divider
// that yields one quotient bit a cycle. A frozen voice only visits the
// envelope state, which moves on. A sample takes longer while an earlier
// result still waits for the receiver; the block accepts nothing while it
// works, and the result waits in an output register.
module multi_voice_synth_mixer import msm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic in_op,
  input  wire logic [1:0] in_voice,
  input  wire logic [27:0] in_freq_step,
  input  wire logic [27:0] in_pulse_width,
  input  wire logic [7:0] in_control_flags,
  input  wire logic in_key_gate,
  input  wire logic in_voice_enable,
  input  wire logic [23:0] in_attack_step,
  input  wire logic [23:0] in_decay_step,
  input  wire logic [23:0] in_sustain_level,
  input  wire logic [23:0] in_release_step,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] out_sample_out
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENV = 3'd1;
  localparam logic [2:0] S_PH = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_WAVE = 3'd4;
  localparam logic [2:0] S_MIX = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [27:0] freq_r [VOICES];
  logic [27:0] pulse_r [VOICES];
  logic [7:0] flags_r [VOICES];
  logic gate_r [VOICES];
  logic on_r [VOICES];
  logic [23:0] att_r [VOICES];
  logic [23:0] dec_r [VOICES];
  logic [23:0] sus_r [VOICES];
  logic [23:0] rel_r [VOICES];
  logic [1:0] est_r [VOICES];
  logic [23:0] lvl_r [VOICES];
  logic [27:0] ph_r [VOICES];
  logic [4:0] nclk_r [VOICES];
  logic [22:0] lfsr_r [VOICES];
  logic [7:0] nbyte_r [VOICES];

  logic [2:0] st_r;
  logic [VW-1:0] v_r;
  logic [VW-1:0] p;
  logic prev_lt_r, prev_hi_r;
  logic [7:0] wave_r;
  logic signed [19:0] acc_r;
  logic signed [15:0] smp_r;
  logic ov_r;
  logic last;
  div_req_t dreq;
  logic dbusy;
  logic [27:0] dquo;

  msm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quo(dquo));

  assign p = v_r - 1'b1;
  assign last = (v_r == VW'(VOICES - 1));
  // A waiting result does not block a new request; the sequencer holds in
  // S_OUT until the output register is free.
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_sample_out = smp_r;

  // Envelope step for the current voice.
  logic gt;
  logic [1:0] es;
  logic [24:0] lsum;
  logic [24:0] ldif;
  logic [23:0] nlvl;
  logic [1:0] nest;
  always_comb begin
    gt = gate_r[v_r] & flags_r[v_r][0];
    es = est_r[v_r];
    if (gt && es == ST_RELEASE) es = ST_ATTACK;
    if (!gt) es = ST_RELEASE;
    nlvl = lvl_r[v_r];
    nest = es;
    lsum = {1'b0, lvl_r[v_r]} + {1'b0, att_r[v_r]};
    ldif = {1'b0, lvl_r[v_r]} - {1'b0, (es == ST_DECAY) ? dec_r[v_r] : rel_r[v_r]};
    unique case (es)
      ST_ATTACK: begin
        if (lsum >= {1'b0, LVL_MAX}) begin
          nlvl = LVL_MAX; nest = ST_DECAY;
        end else nlvl = lsum[23:0];
      end
      ST_DECAY: begin
        if (ldif[24] || ldif[23:0] <= sus_r[v_r]) begin
          nlvl = sus_r[v_r]; nest = ST_SUSTAIN;
        end else nlvl = ldif[23:0];
      end
      ST_SUSTAIN: begin
        if (lvl_r[v_r] != sus_r[v_r]) nest = ST_ATTACK;
      end
      default: nlvl = ldif[24] ? 24'd0 : ldif[23:0];
    endcase
  end

  // Waveform from the new phase.
  logic [27:0] ph;
  logic [7:0] tri_w, saw_w, pul_w, out_w, nb;
  logic [22:0] ns;
  logic nstep;
  always_comb begin
    ph = ph_r[v_r];
    tri_w = ph[27] ? ~ph[26:19] : ph[26:19];
    if (flags_r[v_r][2] && !prev_hi_r) tri_w = ~tri_w;
    saw_w = ph[27:20];
    pul_w = (ph > pulse_r[v_r]) ? 8'h00 : 8'hff;
    nstep = (nclk_r[v_r] != ph[27:23]);
    ns = {lfsr_r[v_r][21:0], lfsr_r[v_r][22] ^ lfsr_r[v_r][17]};
    nb = nstep ? noise_map(ns) : nbyte_r[v_r];
    out_w = 8'hff;
    if (flags_r[v_r][4]) out_w = out_w & tri_w;
    if (flags_r[v_r][5]) out_w = out_w & saw_w;
    if (flags_r[v_r][6]) out_w = out_w & pul_w;
    if (flags_r[v_r][7]) out_w = out_w & nb;
  end

  logic signed [33:0] prod;
  logic signed [19:0] acc_nx;
  assign prod = $signed({1'b0, wave_r} - 9'd128) * $signed({1'b0, lvl_r[v_r]});
  assign acc_nx = acc_r + 20'(prod >>> 18);

  assign dreq.start = (st_r == S_PH) && flags_r[v_r][1] && prev_lt_r;
  assign dreq.num = ph_r[p] * freq_r[v_r];
  assign dreq.den = freq_r[p];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        freq_r[i] <= '0; pulse_r[i] <= '0; flags_r[i] <= '0; gate_r[i] <= 1'b0;
        on_r[i] <= 1'b1; att_r[i] <= '0; dec_r[i] <= '0; sus_r[i] <= '0;
        rel_r[i] <= '0; est_r[i] <= ST_RELEASE; lvl_r[i] <= '0; ph_r[i] <= '0;
        nclk_r[i] <= '0; lfsr_r[i] <= LFSR_INIT; nbyte_r[i] <= '0;
      end
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (in_op == OP_LOAD) begin
              freq_r[in_voice] <= in_freq_step;
              pulse_r[in_voice] <= in_pulse_width;
              flags_r[in_voice] <= in_control_flags;
              gate_r[in_voice] <= in_key_gate;
              on_r[in_voice] <= in_voice_enable;
              att_r[in_voice] <= in_attack_step;
              dec_r[in_voice] <= in_decay_step;
              sus_r[in_voice] <= in_sustain_level;
              rel_r[in_voice] <= in_release_step;
            end else begin
              v_r <= '0; acc_r <= '0; st_r <= S_ENV;
            end
          end
        end
        S_ENV: begin
          if (!on_r[v_r]) begin
            if (last) st_r <= S_OUT;
            else v_r <= v_r + 1'b1;
          end else begin
            lvl_r[v_r] <= nlvl;
            est_r[v_r] <= nest;
            prev_lt_r <= ph_r[p] < freq_r[p];
            prev_hi_r <= ph_r[p][27];
            st_r <= S_PH;
          end
        end
        S_PH: begin
          if (dreq.start) st_r <= S_DIV;
          else begin
            ph_r[v_r] <= ph_r[v_r] + freq_r[v_r];
            st_r <= S_WAVE;
          end
        end
        S_DIV: begin
          if (!dbusy) begin
            ph_r[v_r] <= dquo;
            st_r <= S_WAVE;
          end
        end
        S_WAVE: begin
          wave_r <= out_w;
          if (nstep) begin
            nclk_r[v_r] <= ph[27:23]; lfsr_r[v_r] <= ns; nbyte_r[v_r] <= nb;
          end
          st_r <= S_MIX;
        end
        S_MIX: begin
          acc_r <= acc_nx;
          if (last) st_r <= S_OUT;
          else begin
            v_r <= v_r + 1'b1; st_r <= S_ENV;
          end
        end
        S_OUT: begin
          if (!ov_r) begin
            smp_r <= (acc_r > 20'sd32767) ? 16'sh7fff :
                     (acc_r < -20'sd32768) ? 16'sh8000 : acc_r[15:0];
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |=> (st_r == S_DIV) && dbusy) else $error("divider not started");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == S_OUT) else $error("stray result");
`endif
endmodule
`default_nettype wire

@@ sv/msm_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on msm_pkg.
`default_nettype none
module msm_div import msm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire div_req_t req,
  output logic busy,
  output logic [27:0] quo
);
  logic [55:0] q_r, q_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [27:0] den_r, den_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [29:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    trial = {rem_r, q_r[55]} - {2'b00, den_r};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den; cnt_nxt = 6'd56;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[29]) begin
        rem_nxt = trial[28:0];
        q_nxt = {q_r[54:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[27:0], q_r[55]};
        q_nxt = {q_r[54:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign quo = q_r[27:0];
endmodule
`default_nettype wire
